>>> hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation controller and datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_REDUCE,
		ST_BIT,
		ST_MULMOD,
		ST_DONE
	} mexp_state_t;

	// Multiply-reduce operation selectors
	typedef enum logic [1:0] {
		OP_BASE,
		OP_ACC,
		OP_SQR
	} mexp_op_t;

	typedef struct packed {
		logic     load;      // capture operands
		logic     start_mm;  // start a reduction
		mexp_op_t op;
		logic     shift_e;   // drop exponent bit
		logic     finish;    // present result
	} mexp_cmd_t;

	typedef struct packed {
		logic mm_done;
		logic e_zero;
		logic e_bit;
		logic m_zero;
		logic bits_left;
	} mexp_stat_t;

endpackage

>>> hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply base^exponent mod modulus.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                    | tuser
// s_axis  | in  | base_value, exponent, modulus (96b)   | -
// m_axis  | out | power_mod (32b)                       | divide_error
//
// One request at a time. Each multiply-reduce is a multiply followed by
// 2*OPERAND_WIDTH shift-subtract steps, its result taken on the cycle after.
// The base is reduced first; then each exponent bit up to the highest set
// one takes a squaring (zero bit) or an accumulator multiply and a squaring
// (one bit). A zero modulus skips all reductions and sets divide_error.
// Reset clears control only. The result register holds until taken; the
// sequencer stalls in DONE while it is occupied, and a new request is
// accepted once the finished result has moved into it.
module modular_exponentiation import mexp_pkg::*; #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // base_value, exponent, modulus
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // power_mod
	output logic        m_axis_tuser   // divide_error
);
	localparam int W = OPERAND_WIDTH;
	mexp_cmd_t    cmd;
	mexp_stat_t   stat;
	logic         busy, start, out_free, err;
	logic [W-1:0] acc;
	logic         ovalid_q;
	logic [31:0]  odata_q;
	logic         oerr_q;

	assign s_axis_tready = !busy;
	assign start         = s_axis_tvalid && s_axis_tready;
	// hold in DONE until the result register is free
	assign out_free      = !ovalid_q || m_axis_tready;

	mexp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .out_free(out_free),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	mexp_dp #(.W(W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.b_in(s_axis_tdata[W-1:0]),
		.e_in(s_axis_tdata[32+W-1:32]),
		.m_in(s_axis_tdata[64+W-1:64]),
		.stat(stat), .acc(acc), .err(err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.finish) ovalid_q <= 1'b1;
		else if (m_axis_tready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			odata_q <= err ? 32'd0 : 32'(acc);
			oerr_q  <= err;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = oerr_q;

	// a request is never taken while one is in flight
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !start) else $error("request accepted while busy");
	// a result is written only while the result register is free
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> out_free) else $error("result overwritten");
	// a reduction never starts while the sequencer is idle
	a_mm_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_mm |-> busy) else $error("reduction without request");
endmodule

>>> hw/rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer: walks exponent bits, issues multiply-reduce commands.
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       out_free,
	input  mexp_stat_t stat,
	output mexp_cmd_t  cmd,
	output logic       busy
);
	mexp_state_t state_q, state_d;
	logic        sqr_q, sqr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sqr_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sqr_q   <= sqr_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sqr_d   = sqr_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_LOAD;
			ST_LOAD: begin
				if (stat.m_zero) state_d = ST_DONE;
				else state_d = ST_REDUCE;
			end
			ST_REDUCE: if (stat.mm_done) state_d = ST_BIT;
			ST_BIT: begin
				if (stat.e_zero || !stat.bits_left) state_d = ST_DONE;
				else begin
					state_d = ST_MULMOD;
					sqr_d   = !stat.e_bit;
				end
			end
			ST_MULMOD: begin
				if (stat.mm_done) begin
					if (sqr_q) state_d = ST_BIT;
					else sqr_d = 1'b1;
				end
			end
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_BASE;
		busy     = (state_q != ST_IDLE);
		case (state_q)
			ST_LOAD: begin
				cmd.load     = 1'b0;
				cmd.start_mm = !stat.m_zero;
				cmd.op       = OP_BASE;
			end
			ST_BIT: begin
				cmd.start_mm = !(stat.e_zero || !stat.bits_left);
				cmd.op       = stat.e_bit ? OP_ACC : OP_SQR;
			end
			ST_MULMOD: begin
				cmd.start_mm = stat.mm_done && !sqr_q;
				cmd.op       = OP_SQR;
				cmd.shift_e  = stat.mm_done && sqr_q;
			end
			ST_DONE:   cmd.finish = out_free;
			ST_IDLE:   cmd.load = start;
			default:   cmd = '0;
		endcase
	end
endmodule

>>> hw/rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, multiplier, shift-subtract reducer.
// ----------------------------------------------------------------------------
module mexp_dp import mexp_pkg::*; #(
	parameter int W = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mexp_cmd_t  cmd,
	input  logic [W-1:0] b_in,
	input  logic [W-1:0] e_in,
	input  logic [W-1:0] m_in,
	output mexp_stat_t stat,
	output logic [W-1:0] acc,
	output logic       err
);
	localparam int CW = $clog2(2*W+1);
	logic [W-1:0]   m_q, e_q, acc_q, pw_q;
	logic [2*W-1:0] prod_q;
	logic [W-1:0]   rem_q;
	logic [CW-1:0]  cnt_q;
	logic [$clog2(W+1)-1:0] bits_q;
	logic           run_q, done_q;
	mexp_op_t       op_q;
	logic [W-1:0]   ma, mb;
	logic [W:0]     sh;

	always_comb begin
		ma = pw_q; mb = pw_q;
		case (cmd.op)
			OP_BASE: begin ma = pw_q; mb = W'(1); end
			OP_ACC:  begin ma = acc_q; mb = pw_q; end
			OP_SQR:  begin ma = pw_q; mb = pw_q; end
			default: begin ma = pw_q; mb = pw_q; end
		endcase
	end

	// restoring step: bring next product bit into remainder
	assign sh = {rem_q, prod_q[2*W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			bits_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.load) bits_q <= ($clog2(W+1))'(W);
			else if (cmd.shift_e) bits_q <= bits_q - 1'b1;
			if (cmd.start_mm) begin
				run_q <= 1'b1;
				cnt_q <= CW'(2*W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= m_in;
			e_q   <= e_in;
			pw_q  <= b_in;
			acc_q <= W'(1);
			err   <= (m_in == '0);
		end
		if (cmd.shift_e) e_q <= e_q >> 1;
		if (cmd.start_mm) begin
			prod_q <= ma * mb;
			rem_q  <= '0;
			op_q   <= cmd.op;
		end else if (run_q) begin
			prod_q <= prod_q << 1;
			rem_q  <= (sh >= {1'b0, m_q}) ? W'(sh - {1'b0, m_q}) : sh[W-1:0];
		end
		if (done_q) begin
			if (op_q == OP_ACC) acc_q <= rem_q;
			else pw_q <= rem_q;
		end
		if (cmd.finish && err) acc_q <= '0;
	end

	assign acc            = acc_q;
	assign stat.mm_done   = done_q;
	assign stat.e_zero    = (e_q == '0);
	assign stat.e_bit     = e_q[0];
	assign stat.m_zero    = (m_q == '0);
	assign stat.bits_left = (bits_q != '0);
endmodule
